// File: rtl/core/packet_ack_delivery_tracker_unit_assert.svh
// Assertion macros for the delivery tracker. Empty under synthesis.
`ifndef PACKET_ACK_DELIVERY_TRACKER_UNIT_ASSERT_SVH
`define PACKET_ACK_DELIVERY_TRACKER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Checked on every rising aclk edge, held off while aresetn is low.
`define PADT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
// Checked on every rising aclk edge, reset included.
`define PADT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);
`else
`define PADT_ASSERT(lbl, prop, msg)
`define PADT_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: rtl/core/padt_pkg.sv
// ----------------------------------------------------------------------------
// padt_pkg
// Shared types and codes of the packet ack delivery tracker.
// ----------------------------------------------------------------------------
package padt_pkg;

    localparam logic [1:0] CMD_SEND = 2'd0;
    localparam logic [1:0] CMD_RECV = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;

    localparam logic [1:0] KIND_SEND    = 2'd0;
    localparam logic [1:0] KIND_VERDICT = 2'd1;
    localparam logic [1:0] KIND_NOTICE  = 2'd2;

    localparam logic [1:0] CFG_SEND_ACKS  = 2'd0;
    localparam logic [1:0] CFG_TRACK_ACKS = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT    = 2'd2;

    localparam logic [7:0]  MAX_RANGE_COUNT = 8'd255;
    localparam logic [31:0] TIMEOUT_RESET   = 32'd2500;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] rx_seq;
        logic        rx_has_ack;
        logic [15:0] rx_ack_start;
        logic [7:0]  rx_ack_count;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] seq;
        logic        accepted;
        logic        delivered;
        logic        has_ack;
        logic [15:0] ack_start;
        logic [7:0]  ack_count;
        logic        overflow;
        logic        last;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEND_RD,
        ST_SEND_EMIT,
        ST_RX_RD,
        ST_RX_EMIT,
        ST_W_LOAD,
        ST_W_EVAL,
        ST_T_LOAD,
        ST_T_EVAL,
        ST_FLUSH
    } state_t;

endpackage

// File: rtl/core/padt_ram.sv
// ----------------------------------------------------------------------------
// padt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module padt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: rtl/core/packet_ack_delivery_tracker_unit.sv
// ----------------------------------------------------------------------------
// packet_ack_delivery_tracker_unit
// Sequence numbering, pending ack ranges and delivery notices for one link end.
// ----------------------------------------------------------------------------
// One item is handled at a time; s_ready is high only while the sequencer is
// idle. A send goes through a read, an emit and the flush state; a receive
// through a read, an emit, its ack walk and the flush state. A tick loads and
// evaluates the oldest in-flight packet, again for each one that timed out,
// then flushes. The ack walk emits each notice after one in-flight RAM read
// and one compare, and steps over each sequence number of the range that
// matches no packet with a compare alone; emit states wait while the result
// side stalls. In-flight packets and pending ack ranges live in two RAMs with
// registered read data; the fill counts bound every read, so no clearing pass
// is needed after reset. Results go through a one-entry hold register so that
// last can be set on the final result of each item, then an output register,
// so the result side may stall freely.
module packet_ack_delivery_tracker_unit
    import padt_pkg::*;
#(
    parameter int SEQ_BITS       = 16,
    parameter int INFLIGHT_DEPTH = 32,
    parameter int PENDING_DEPTH  = 16,
    parameter int TIME_BITS      = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_item,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_item,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
`include "packet_ack_delivery_tracker_unit_assert.svh"

    localparam int IIW  = $clog2(INFLIGHT_DEPTH);
    localparam int IFW  = $clog2(INFLIGHT_DEPTH + 1);
    localparam int PIW  = $clog2(PENDING_DEPTH);
    localparam int PFW  = $clog2(PENDING_DEPTH + 1);
    localparam int CMPW = TIME_BITS + 32;
    localparam int IW   = SEQ_BITS + TIME_BITS;
    localparam int PW   = SEQ_BITS + 8;

    function automatic logic [15:0] seq_out(input logic [SEQ_BITS-1:0] v);
        logic [SEQ_BITS+15:0] e;
        e = {16'd0, v};
        return e[15:0];
    endfunction

    function automatic logic [SEQ_BITS-1:0] seq_in(input logic [15:0] v);
        logic [SEQ_BITS+15:0] e;
        e = {{SEQ_BITS{1'b0}}, v};
        return e[SEQ_BITS-1:0];
    endfunction

    // configuration
    logic        send_acks_reg;
    logic        track_acks_reg;
    logic [31:0] timeout_reg;

    // control state
    state_t              state_reg, state_next;
    in_item_t            in_reg;
    logic [SEQ_BITS-1:0] out_seq_reg, out_seq_next;
    logic [SEQ_BITS-1:0] exp_seq_reg, exp_seq_next;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [IIW-1:0]      inf_head_reg, inf_head_next;
    logic [IFW-1:0]      inf_fill_reg, inf_fill_next;
    logic [PIW-1:0]      pnd_head_reg, pnd_head_next;
    logic [PFW-1:0]      pnd_fill_reg, pnd_fill_next;
    logic [SEQ_BITS:0]   nxt_reg, nxt_next;
    logic [SEQ_BITS:0]   end_reg, end_next;

    // result path: hold register, then output register
    out_item_t hold_reg, hold_next;
    logic      hold_valid_reg, hold_valid_next;
    out_item_t out_reg, out_next;
    logic      out_valid_reg, out_valid_next;

    // memories
    logic            inf_we;
    logic [IIW-1:0]  inf_waddr;
    logic [IW-1:0]   inf_wdata, inf_rdata;
    logic            pnd_we;
    logic [PIW-1:0]  pnd_waddr, pnd_raddr;
    logic [PW-1:0]   pnd_wdata, pnd_rdata;

    // derived values
    logic                 slot_free, emit_ok, in_acc;
    logic [IFW:0]         inf_sum;
    logic [IIW-1:0]       inf_tail;
    logic [PFW:0]         pnd_sum, pnd_sum_m1;
    logic [PIW-1:0]       pnd_tail, pnd_bottom;
    logic [SEQ_BITS-1:0]  f_seq, p_start, rx_s, ack_s;
    logic [TIME_BITS-1:0] f_time, age;
    logic [7:0]           p_count;
    logic [SEQ_BITS:0]    f_ext;
    logic                 walk_go, timed_out, inf_full;
    logic                 emit_now;

    padt_ram #(.WIDTH(IW), .DEPTH(INFLIGHT_DEPTH)) u_inflight_ram (
        .aclk  (aclk),
        .we    (inf_we),
        .waddr (inf_waddr),
        .wdata (inf_wdata),
        .raddr (inf_head_reg),
        .rdata (inf_rdata)
    );

    padt_ram #(.WIDTH(PW), .DEPTH(PENDING_DEPTH)) u_pending_ram (
        .aclk  (aclk),
        .we    (pnd_we),
        .waddr (pnd_waddr),
        .wdata (pnd_wdata),
        .raddr (pnd_raddr),
        .rdata (pnd_rdata)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_item    = out_reg;

    assign in_acc    = s_valid && s_ready;
    assign slot_free = !out_valid_reg || m_ready;
    assign emit_ok   = !hold_valid_reg || slot_free;

    // queue positions, wrapped for any depth
    assign inf_sum  = {1'b0, {(IFW - IIW){1'b0}}, inf_head_reg} + {1'b0, inf_fill_reg};
    assign inf_tail = (inf_sum >= (IFW + 1)'(INFLIGHT_DEPTH))
                    ? IIW'(inf_sum - (IFW + 1)'(INFLIGHT_DEPTH)) : IIW'(inf_sum);
    assign pnd_sum  = {1'b0, {(PFW - PIW){1'b0}}, pnd_head_reg} + {1'b0, pnd_fill_reg};
    assign pnd_tail = (pnd_sum >= (PFW + 1)'(PENDING_DEPTH))
                    ? PIW'(pnd_sum - (PFW + 1)'(PENDING_DEPTH)) : PIW'(pnd_sum);
    // newest range; only used while the queue is not empty
    assign pnd_sum_m1 = pnd_sum - (PFW + 1)'(1);
    assign pnd_bottom = (pnd_sum_m1 >= (PFW + 1)'(PENDING_DEPTH))
                      ? PIW'(pnd_sum_m1 - (PFW + 1)'(PENDING_DEPTH)) : PIW'(pnd_sum_m1);
    assign pnd_raddr  = (state_reg == ST_RX_RD) ? pnd_bottom : pnd_head_reg;

    assign {f_seq, f_time}    = inf_rdata;
    assign {p_start, p_count} = pnd_rdata;
    assign f_ext    = {1'b0, f_seq};
    assign rx_s     = seq_in(in_reg.rx_seq);
    assign ack_s    = seq_in(in_reg.rx_ack_start);
    assign inf_full = (inf_fill_reg >= IFW'(INFLIGHT_DEPTH));
    assign walk_go  = (nxt_reg < end_reg) && (inf_fill_reg != '0);
    assign age      = now_reg - f_time;
    assign timed_out = (inf_fill_reg != '0)
                     && ({{(CMPW - TIME_BITS){1'b0}}, age}
                         > {{(CMPW - 32){1'b0}}, timeout_reg});

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (s_item.command)
                        CMD_SEND: state_next = ST_SEND_RD;
                        CMD_RECV: state_next = ST_RX_RD;
                        CMD_TICK: state_next = ST_T_LOAD;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SEND_RD:   state_next = ST_SEND_EMIT;
            ST_SEND_EMIT: if (emit_ok) state_next = ST_FLUSH;
            ST_RX_RD:     state_next = ST_RX_EMIT;
            ST_RX_EMIT: begin
                if (emit_ok) begin
                    state_next = (track_acks_reg && in_reg.rx_has_ack) ? ST_W_LOAD : ST_FLUSH;
                end
            end
            ST_W_LOAD: state_next = ST_W_EVAL;
            ST_W_EVAL: begin
                priority if (!walk_go) begin
                    state_next = ST_FLUSH;
                end else if (f_ext <= nxt_reg) begin
                    if (emit_ok) state_next = ST_W_LOAD;
                end else begin
                    state_next = ST_W_EVAL;
                end
            end
            ST_T_LOAD: state_next = ST_T_EVAL;
            ST_T_EVAL: begin
                if (!timed_out) begin
                    state_next = ST_FLUSH;
                end else if (emit_ok) begin
                    state_next = ST_T_LOAD;
                end
            end
            ST_FLUSH: if (emit_ok) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // datapath and result emission
    always_comb begin
        out_seq_next    = out_seq_reg;
        exp_seq_next    = exp_seq_reg;
        now_next        = now_reg;
        inf_head_next   = inf_head_reg;
        inf_fill_next   = inf_fill_reg;
        pnd_head_next   = pnd_head_reg;
        pnd_fill_next   = pnd_fill_reg;
        nxt_next        = nxt_reg;
        end_next        = end_reg;
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        inf_we          = 1'b0;
        inf_waddr       = inf_tail;
        inf_wdata       = {out_seq_reg, now_reg};
        pnd_we          = 1'b0;
        pnd_waddr       = pnd_tail;
        pnd_wdata       = {rx_s, 8'd1};

        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc && s_item.command == CMD_TICK) begin
                    now_next = now_reg + TIME_BITS'(1);
                end
            end
            ST_SEND_EMIT: begin
                if (emit_ok) begin
                    hold_next            = '0;
                    hold_next.kind       = KIND_SEND;
                    hold_next.seq        = seq_out(out_seq_reg);
                    out_seq_next         = out_seq_reg + SEQ_BITS'(1);
                    if (track_acks_reg) begin
                        if (inf_full) begin
                            hold_next.overflow = 1'b1;
                        end else begin
                            inf_we        = 1'b1;
                            inf_fill_next = inf_fill_reg + IFW'(1);
                        end
                    end
                    if (send_acks_reg && pnd_fill_reg != '0) begin
                        hold_next.has_ack   = 1'b1;
                        hold_next.ack_start = seq_out(p_start);
                        hold_next.ack_count = p_count;
                        pnd_head_next = (pnd_head_reg == PIW'(PENDING_DEPTH - 1))
                                      ? '0 : pnd_head_reg + PIW'(1);
                        pnd_fill_next = pnd_fill_reg - PFW'(1);
                    end
                end
            end
            ST_RX_EMIT: begin
                if (emit_ok) begin
                    hold_next      = '0;
                    hold_next.kind = KIND_VERDICT;
                    hold_next.seq  = in_reg.rx_seq;
                    if (rx_s >= exp_seq_reg) begin
                        hold_next.accepted = 1'b1;
                        exp_seq_next       = rx_s + SEQ_BITS'(1);
                        if (send_acks_reg) begin
                            // extend the newest range, else open a new one
                            priority if (pnd_fill_reg != '0
                                && ({1'b0, p_start} + {{(SEQ_BITS - 7){1'b0}}, p_count})
                                   == {1'b0, rx_s}
                                && p_count < MAX_RANGE_COUNT) begin
                                pnd_we    = 1'b1;
                                pnd_waddr = pnd_bottom;
                                pnd_wdata = {p_start, p_count + 8'd1};
                            end else if (pnd_fill_reg >= PFW'(PENDING_DEPTH)) begin
                                hold_next.overflow = 1'b1;
                            end else begin
                                pnd_we        = 1'b1;
                                pnd_fill_next = pnd_fill_reg + PFW'(1);
                            end
                        end
                    end
                    nxt_next = {1'b0, ack_s};
                    end_next = {1'b0, ack_s} + {{(SEQ_BITS - 7){1'b0}}, in_reg.rx_ack_count};
                end
            end
            ST_W_EVAL: begin
                if (walk_go) begin
                    if (f_ext <= nxt_reg) begin
                        if (emit_ok) begin
                            hold_next           = '0;
                            hold_next.kind      = KIND_NOTICE;
                            hold_next.seq       = seq_out(f_seq);
                            hold_next.delivered = (f_ext == nxt_reg);
                            inf_head_next = (inf_head_reg == IIW'(INFLIGHT_DEPTH - 1))
                                          ? '0 : inf_head_reg + IIW'(1);
                            inf_fill_next = inf_fill_reg - IFW'(1);
                            if (f_ext == nxt_reg) begin
                                nxt_next = nxt_reg + (SEQ_BITS + 1)'(1);
                            end
                        end
                    end else begin
                        nxt_next = nxt_reg + (SEQ_BITS + 1)'(1);
                    end
                end
            end
            ST_T_EVAL: begin
                if (timed_out && emit_ok) begin
                    hold_next      = '0;
                    hold_next.kind = KIND_NOTICE;
                    hold_next.seq  = seq_out(f_seq);
                    inf_head_next  = (inf_head_reg == IIW'(INFLIGHT_DEPTH - 1))
                                   ? '0 : inf_head_reg + IIW'(1);
                    inf_fill_next  = inf_fill_reg - IFW'(1);
                end
            end
            default: begin
            end
        endcase

        // a new result pushes the held one out, not yet marked last
        if (emit_now) begin
            hold_valid_next = 1'b1;
            if (hold_valid_reg) begin
                out_next        = hold_reg;
                out_next.last   = 1'b0;
                out_valid_next  = 1'b1;
            end
        end
        if (state_reg == ST_FLUSH) begin
            if (hold_valid_reg && slot_free) begin
                out_next        = hold_reg;
                out_next.last   = 1'b1;
                out_valid_next  = 1'b1;
                hold_valid_next = 1'b0;
            end
        end
    end

    // marks a cycle in which a fresh result enters the hold register
    always_comb begin
        emit_now = 1'b0;
        unique case (state_reg)
            ST_SEND_EMIT, ST_RX_EMIT: emit_now = emit_ok;
            ST_W_EVAL:  emit_now = walk_go && (f_ext <= nxt_reg) && emit_ok;
            ST_T_EVAL:  emit_now = timed_out && emit_ok;
            default:    emit_now = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            send_acks_reg  <= 1'b1;
            track_acks_reg <= 1'b1;
            timeout_reg    <= TIMEOUT_RESET;
            out_seq_reg    <= '0;
            exp_seq_reg    <= '0;
            now_reg        <= '0;
            inf_head_reg   <= '0;
            inf_fill_reg   <= '0;
            pnd_head_reg   <= '0;
            pnd_fill_reg   <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            out_seq_reg    <= out_seq_next;
            exp_seq_reg    <= exp_seq_next;
            now_reg        <= now_next;
            inf_head_reg   <= inf_head_next;
            inf_fill_reg   <= inf_fill_next;
            pnd_head_reg   <= pnd_head_next;
            pnd_fill_reg   <= pnd_fill_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_SEND_ACKS:  send_acks_reg  <= cfg_data[0];
                    CFG_TRACK_ACKS: track_acks_reg <= cfg_data[0];
                    CFG_TIMEOUT:    timeout_reg    <= cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            in_reg <= s_item;
        end
        nxt_reg  <= nxt_next;
        end_reg  <= end_next;
        hold_reg <= hold_next;
        out_reg  <= out_next;
    end

    `PADT_ASSERT(a_idle_hold_empty, s_ready |-> !hold_valid_reg, "hold busy while idle")
    `PADT_ASSERT(a_inf_fill_bound, inf_fill_reg <= IFW'(INFLIGHT_DEPTH), "in-flight overfill")
    `PADT_ASSERT(a_pnd_fill_bound, pnd_fill_reg <= PFW'(PENDING_DEPTH), "pending overfill")
    `PADT_ASSERT(a_walk_bound, (state_reg == ST_W_EVAL) |-> (nxt_reg <= end_reg), "walk past end")
    `PADT_ASSERT(a_flush_done, (state_reg == ST_FLUSH && state_next == ST_IDLE) |=> !hold_valid_reg, "flush left a held item")
endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the packet ack delivery tracker. A scoreboard class
// keeps its own copy of the tracker state, predicts every result of each
// accepted item, and checks results in order. Directed items come first, then
// random sequences of sends, receives, ack walks, ticks, queue
// overflows and noise, across several register settings.
// ----------------------------------------------------------------------------
module tb_top;
    import padt_pkg::*;

    localparam logic [1:0] CMD_NONE = 2'd3;   // unused command, ignored by the block
    localparam int WATCHDOG_LIMIT  = 5000;    // idle cycles before the run is abandoned
    localparam int DRAIN_CYCLES    = 400;     // longest ack walk plus output stalls
    localparam int HOLD_CYCLES     = 300;

    class delivery_scoreboard;
        logic        acks_on;
        logic        track_on;
        logic [31:0] timeout;
        logic [15:0] out_seq;
        logic [15:0] exp_seq;
        logic [31:0] now;
        logic [15:0] fl_seq[32];
        logic [31:0] fl_time[32];
        int          fl_head, fl_fill;
        logic [15:0] pend_start[16];
        logic [7:0]  pend_count[16];
        int          pend_head, pend_fill;
        out_item_t   expected_q[$];
        int          fails, checked, notices, overflows;

        function void reset_state();
            acks_on = 1'b1; track_on = 1'b1; timeout = TIMEOUT_RESET;
            out_seq = '0; exp_seq = '0; now = '0;
            fl_head = 0; fl_fill = 0; pend_head = 0; pend_fill = 0;
            expected_q.delete();
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] d);
            case (idx)
                CFG_SEND_ACKS:  acks_on = d[0];
                CFG_TRACK_ACKS: track_on = d[0];
                CFG_TIMEOUT:    timeout = d;
                default: ;
            endcase
        endfunction

        function void push_result(logic [1:0] kind, logic [15:0] seq, logic acc, logic del,
                                  logic has, logic [15:0] ast, logic [7:0] acnt, logic ovf);
            out_item_t r;
            r = '{kind: kind, seq: seq, accepted: acc, delivered: del, has_ack: has,
                  ack_start: ast, ack_count: acnt, overflow: ovf, last: 1'b0};
            if (kind == KIND_NOTICE) notices++;
            if (ovf) overflows++;
            expected_q.push_back(r);
        endfunction

        // Returns 1 when the pending range queue is full and the ack is dropped.
        function logic add_pending(logic [15:0] s);
            int b, t;
            if (pend_fill > 0) begin
                b = (pend_head + pend_fill - 1) % 16;
                if (int'(pend_start[b]) + int'(pend_count[b]) == int'(s)
                        && pend_count[b] < MAX_RANGE_COUNT) begin
                    pend_count[b]++;
                    return 1'b0;
                end
            end
            if (pend_fill >= 16) return 1'b1;
            t = (pend_head + pend_fill) % 16;
            pend_start[t] = s;
            pend_count[t] = 8'd1;
            pend_fill++;
            return 1'b0;
        endfunction

        function void note_input(in_item_t it);
            int n, t, nxt, fin;
            logic ovf, has, acc;
            logic [15:0] ast, f;
            logic [7:0] acnt;
            n = expected_q.size();
            case (it.command)
                CMD_SEND: begin
                    ovf = 1'b0; has = 1'b0; ast = '0; acnt = '0;
                    if (track_on) begin
                        if (fl_fill >= 32) ovf = 1'b1;
                        else begin
                            t = (fl_head + fl_fill) % 32;
                            fl_seq[t] = out_seq; fl_time[t] = now; fl_fill++;
                        end
                    end
                    if (acks_on && pend_fill > 0) begin
                        has = 1'b1; ast = pend_start[pend_head]; acnt = pend_count[pend_head];
                        pend_head = (pend_head + 1) % 16; pend_fill--;
                    end
                    push_result(KIND_SEND, out_seq, 1'b0, 1'b0, has, ast, acnt, ovf);
                    out_seq++;
                end
                CMD_RECV: begin
                    acc = 1'b0; ovf = 1'b0;
                    if (it.rx_seq >= exp_seq) begin
                        acc = 1'b1;
                        exp_seq = it.rx_seq + 16'd1;
                        if (acks_on) ovf = add_pending(it.rx_seq);
                    end
                    push_result(KIND_VERDICT, it.rx_seq, acc, 1'b0, 1'b0, '0, '0, ovf);
                    if (track_on && it.rx_has_ack) begin
                        nxt = it.rx_ack_start;
                        fin = nxt + int'(it.rx_ack_count);   // no wrap on the range end
                        while (nxt < fin && fl_fill > 0) begin
                            f = fl_seq[fl_head];
                            if (int'(f) <= nxt) begin
                                push_result(KIND_NOTICE, f, 1'b0, int'(f) == nxt,
                                            1'b0, '0, '0, 1'b0);
                                if (int'(f) == nxt) nxt++;
                                fl_head = (fl_head + 1) % 32; fl_fill--;
                            end else nxt++;
                        end
                    end
                end
                CMD_TICK: begin
                    now++;
                    while (fl_fill > 0 && (now - fl_time[fl_head]) > timeout) begin
                        push_result(KIND_NOTICE, fl_seq[fl_head], 1'b0, 1'b0,
                                    1'b0, '0, '0, 1'b0);
                        fl_head = (fl_head + 1) % 32; fl_fill--;
                    end
                end
                default: ;
            endcase
            if (expected_q.size() > n) expected_q[expected_q.size() - 1].last = 1'b1;
        endfunction

        task report(string msg);
            fails++;
            $display("tb: mismatch: %s", msg);
        endtask

        task check_result(out_item_t got);
            out_item_t e;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result kind %0d seq %0h", got.kind, got.seq));
                return;
            end
            e = expected_q[0];
            expected_q.delete(0);
            checked++;
            if (got.kind !== e.kind)
                report($sformatf("kind %0d, want %0d (seq %0h)", got.kind, e.kind, e.seq));
            if (got.seq !== e.seq) report($sformatf("seq %0h, want %0h", got.seq, e.seq));
            if (got.accepted !== e.accepted)
                report($sformatf("accepted %0b, want %0b (seq %0h)", got.accepted, e.accepted, e.seq));
            if (got.delivered !== e.delivered)
                report($sformatf("delivered %0b, want %0b (seq %0h)", got.delivered, e.delivered, e.seq));
            if (got.has_ack !== e.has_ack)
                report($sformatf("has_ack %0b, want %0b (seq %0h)", got.has_ack, e.has_ack, e.seq));
            if (got.ack_start !== e.ack_start)
                report($sformatf("ack_start %0h, want %0h", got.ack_start, e.ack_start));
            if (got.ack_count !== e.ack_count)
                report($sformatf("ack_count %0d, want %0d", got.ack_count, e.ack_count));
            if (got.overflow !== e.overflow)
                report($sformatf("overflow %0b, want %0b (seq %0h)", got.overflow, e.overflow, e.seq));
            if (got.last !== e.last)
                report($sformatf("last %0b, want %0b (seq %0h)", got.last, e.last, e.seq));
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid, s_ready;
    in_item_t    s_item;
    logic        m_valid, m_ready;
    out_item_t   m_item;
    logic        cfg_valid, cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    delivery_scoreboard sb;
    int  items_sent;
    bit  calm;       // no idling on either side
    bit  hold_req;   // receiver holds off for a long stretch
    int  idle_cycles;

    packet_ack_delivery_tracker_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Results are checked at the edge where they are taken.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_item);
    end

    // Watchdog: any handshake restarts the count.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: watchdog expired, %0d results outstanding", sb.expected_q.size());
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver: random stall bursts, a long hold-off on request, none when calm.
    initial begin
        m_ready = 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else if (calm || $urandom_range(0, 2) != 0) begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end else begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end
        end
    end

    // Offer one item and wait for it to be taken; maybe leave a gap afterward.
    task push_item(in_item_t it);
        s_item  <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(it);
        items_sent++;
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
    endtask

    task push_cmd(logic [1:0] cmd, logic [15:0] seq, logic has, logic [15:0] ast,
                  logic [7:0] acnt);
        in_item_t it;
        it = '{command: cmd, rx_seq: seq, rx_has_ack: has, rx_ack_start: ast,
               rx_ack_count: acnt};
        push_item(it);
    endtask

    // Wait for every expected result, then for any silent work to end.
    task drain();
        s_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Leaves cfg_valid high so that writes can follow back to back.
    task write_reg(logic [1:0] idx, logic [31:0] d);
        cfg_index <= idx;
        cfg_data  <= d;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, d);
    endtask

    task apply_setting(logic acks, logic track, logic [31:0] tmo);
        drain();
        write_reg(CFG_SEND_ACKS, {31'b0, acks});
        write_reg(CFG_TRACK_ACKS, {31'b0, track});
        write_reg(CFG_TIMEOUT, tmo);
        cfg_valid <= 1'b0;
    endtask

    // One random sequence; mostly well-formed traffic, some noise and floods.
    task random_sequence();
        int r, k;
        in_item_t it;
        logic [15:0] base;
        r = $urandom_range(0, 19);
        if (r < 6) begin
            repeat ($urandom_range(1, 6)) push_cmd(CMD_SEND, '0, 1'b0, '0, '0);
        end else if (r < 11) begin
            k = $urandom_range(0, 2);
            base = sb.out_seq - 16'($urandom_range(1, 8));
            push_cmd(CMD_RECV, sb.exp_seq + 16'(k), 1'($urandom_range(0, 1)), base,
                     8'($urandom_range(1, 10)));
        end else if (r < 14) begin
            base = (sb.fl_fill > 0) ? sb.fl_seq[sb.fl_head] : sb.out_seq;
            push_cmd(CMD_RECV, sb.exp_seq, 1'b1, base - 16'($urandom_range(0, 2)),
                     8'($urandom_range(1, 40)));
        end else if (r < 17) begin
            repeat ($urandom_range(1, 5)) push_cmd(CMD_TICK, '0, 1'b0, '0, '0);
        end else if (r == 17) begin
            it = in_item_t'({$urandom, $urandom});
            push_item(it);
        end else if (r == 18) begin
            // gapped numbers: each opens a new range until the queue overflows
            repeat (18) push_cmd(CMD_RECV, sb.exp_seq + 16'd1, 1'b0, '0, '0);
        end else begin
            repeat (34) push_cmd(CMD_SEND, '0, 1'b0, '0, '0);
        end
    endtask

    initial begin
        sb = new();
        sb.reset_state();
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_item    = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        calm      = 1'b0;
        hold_req  = 1'b0;
        items_sent = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty queues, refusal, merge, ranges, wraps, ignored command.
        push_cmd(CMD_SEND, '0, 1'b0, '0, '0);
        push_cmd(CMD_TICK, '0, 1'b0, '0, '0);
        push_cmd(CMD_RECV, 16'd0, 1'b0, '0, '0);
        push_cmd(CMD_RECV, 16'd0, 1'b1, 16'd0, 8'd0);
        push_cmd(CMD_RECV, 16'd1, 1'b0, '0, '0);
        push_cmd(CMD_RECV, 16'd5, 1'b0, '0, '0);
        push_cmd(CMD_SEND, '0, 1'b0, '0, '0);
        push_cmd(CMD_SEND, '0, 1'b0, '0, '0);
        push_cmd(CMD_SEND, '0, 1'b0, '0, '0);
        push_cmd(CMD_RECV, 16'd6, 1'b1, 16'd2, 8'd1);
        push_cmd(CMD_RECV, 16'd7, 1'b1, 16'd0, 8'd255);
        push_cmd(CMD_SEND, '0, 1'b0, '0, '0);
        push_cmd(CMD_SEND, '0, 1'b0, '0, '0);
        push_cmd(CMD_RECV, 16'hFFFF, 1'b1, 16'hFFFF, 8'd255);
        push_cmd(CMD_RECV, 16'd0, 1'b1, 16'd5, 8'd1);
        push_cmd(CMD_NONE, 16'hFFFF, 1'b1, 16'hFFFF, 8'hFF);
        push_cmd(CMD_SEND, '0, 1'b0, '0, '0);
        push_cmd(CMD_RECV, 16'd3, 1'b1, 16'hFFFF, 8'd255);

        // Zero timeout: sent packets fail on the next tick.
        apply_setting(1'b1, 1'b1, 32'd0);
        push_cmd(CMD_SEND, '0, 1'b0, '0, '0);
        push_cmd(CMD_SEND, '0, 1'b0, '0, '0);
        push_cmd(CMD_TICK, '0, 1'b0, '0, '0);

        // Short timeout, with a long receiver hold-off while items keep coming.
        apply_setting(1'b1, 1'b1, 32'd3);
        hold_req = 1'b1;
        repeat (12) push_cmd(CMD_SEND, '0, 1'b0, '0, '0);
        while (items_sent < 70) random_sequence();

        apply_setting(1'b0, 1'b1, 32'd1);
        while (items_sent < 95) random_sequence();
        apply_setting(1'b1, 1'b0, 32'hFFFF_FFFF);
        while (items_sent < 120) random_sequence();
        apply_setting(1'b0, 1'b0, 32'd2);
        while (items_sent < 145) random_sequence();
        apply_setting(1'b1, 1'b1, 32'd4);
        while (items_sent < 175) random_sequence();
        calm = 1'b1;
        while (items_sent < 200) random_sequence();

        drain();
        $display("tb: %0d items sent, %0d results checked (%0d notices, %0d overflow flags)",
                 items_sent, sb.checked, sb.notices, sb.overflows);
        $display("tb: covered refusal, range merge and overflow, ack walks, timeouts, setups");
        if (sb.fails == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: %0d mismatches", sb.fails);
            $display("tb: failure");
        end
        $finish;
    end
endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/padt_pkg.sv
rtl/core/padt_ram.sv
rtl/core/packet_ack_delivery_tracker_unit.sv
bench/tb_top.sv
